>>> hdl/pnew_pkg.sv
`default_nettype none
package pnew_pkg;

	// Fixed field widths of the pixel and result words
	localparam int PIX_W    = 24;
	localparam int CFG_W    = 11;
	localparam int COORD_W  = 10;
	localparam int WEIGHT_W = 7;
	localparam int OUT_W    = 2 * COORD_W + 4 * WEIGHT_W;

	typedef logic [PIX_W-1:0]    pixel_t;
	typedef logic [CFG_W-1:0]    cfg_data_t;
	typedef logic [COORD_W-1:0]  coord_t;
	typedef logic [WEIGHT_W-1:0] weight_t;
	typedef logic [0:0]          cfg_index_t;

	// Configuration register indexes
	localparam cfg_index_t REG_FRAME_WIDTH  = 1'd0;
	localparam cfg_index_t REG_FRAME_HEIGHT = 1'd1;

	localparam cfg_data_t FRAME_WIDTH_RST  = 11'd160;
	localparam cfg_data_t FRAME_HEIGHT_RST = 11'd120;

	// Kinds of result one pixel can release, in delivery order
	typedef logic [2:0] res_mask_t;
	localparam res_mask_t RES_ABOVE = 3'b001;  // pixel one row up, same column
	localparam res_mask_t RES_LEFT  = 3'b010;  // last row, one column to the left
	localparam res_mask_t RES_HERE  = 3'b100;  // last row, last column, this pixel

	localparam weight_t WEIGHT_MAX = 7'd100;
	localparam weight_t WEIGHT_MIN = 7'd1;

	// trunc(100 * exp(-sqrt(n))) for n = 0..15
	localparam weight_t WEIGHT_LUT [16] = '{
		7'd100, 7'd36, 7'd24, 7'd17, 7'd13, 7'd10, 7'd8, 7'd7,
		7'd5,   7'd4,  7'd4,  7'd3,  7'd3,  7'd2,  7'd2, 7'd2
	};

	// One item handed from the weight stage to the result sequencer
	typedef struct packed {
		coord_t    row;
		coord_t    col;
		res_mask_t mask;
		weight_t   wa_up;
		weight_t   wa_dn;
		weight_t   wa_lf;
		weight_t   wa_rt;
		weight_t   wb_up;
		weight_t   wb_lf;
		weight_t   wb_rt;
		weight_t   wc_up;
		weight_t   wc_lf;
	} item_t;

	// Edge weight of two pixels; any channel apart by 4 or more, or n >= 16, gives WEIGHT_MIN
	function automatic weight_t edge_weight(input pixel_t a, input pixel_t b);
		logic [7:0] d;
		logic [1:0] dl;
		logic       far;
		logic [4:0] n;
		far = 1'b0;
		n   = '0;
		for (int k = 0; k < 3; k++) begin
			d   = (a[8*k +: 8] > b[8*k +: 8]) ? a[8*k +: 8] - b[8*k +: 8]
			                                  : b[8*k +: 8] - a[8*k +: 8];
			far = far | (d[7:2] != 6'd0);
			dl  = d[1:0];
			n   = n + ({3'd0, dl} * {3'd0, dl});
		end
		return (far || n[4]) ? WEIGHT_MIN : WEIGHT_LUT[n[3:0]];
	endfunction

endpackage
`default_nettype wire

>>> hdl/pnew_line_buf.sv
`default_nettype none
module pnew_line_buf #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                clk,
	input  logic                en,
	input  logic [AW-1:0]       wr_addr,
	input  logic [AW-1:0]       rd_addr,
	input  pnew_pkg::pixel_t    newer_wdata,
	input  pnew_pkg::pixel_t    older_wdata,
	output pnew_pkg::pixel_t    newer_rdata,
	output pnew_pkg::pixel_t    older_rdata
);

	pnew_pkg::pixel_t newer_mem [DEPTH];
	pnew_pkg::pixel_t older_mem [DEPTH];
	pnew_pkg::pixel_t newer_rd_q;
	pnew_pkg::pixel_t older_rd_q;

	// Read ahead in the newer row, read-modify-write the older row at the current column
	always_ff @(posedge clk) begin
		if (en) begin
			newer_rd_q         <= newer_mem[rd_addr];
			older_rd_q         <= older_mem[wr_addr];
			newer_mem[wr_addr] <= newer_wdata;
			older_mem[wr_addr] <= older_wdata;
		end
	end

	assign newer_rdata = newer_rd_q;
	assign older_rdata = older_rd_q;

	// Look-ahead read never lands on the entry being written
	a_no_rw_clash: assert property (@(posedge clk) en |-> rd_addr != wr_addr)
		else $error("line buffer read and write hit the same entry");

endmodule
`default_nettype wire

>>> hdl/pnew_result_seq.sv
`default_nettype none
module pnew_result_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  pnew_pkg::item_t              item,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [pnew_pkg::OUT_W-1:0]   m_axis_tdata,
	output logic                         m_axis_tlast
);

	pnew_pkg::item_t     item_q;
	pnew_pkg::res_mask_t mask_q;
	pnew_pkg::res_mask_t sel;
	pnew_pkg::res_mask_t mask_left;
	logic                out_free;
	logic                emit;
	pnew_pkg::coord_t    res_row;
	pnew_pkg::coord_t    res_col;
	pnew_pkg::weight_t   res_up;
	pnew_pkg::weight_t   res_dn;
	pnew_pkg::weight_t   res_lf;
	pnew_pkg::weight_t   res_rt;
	logic                out_valid_q;
	logic [pnew_pkg::OUT_W-1:0] out_data_q;
	logic                out_last_q;

	// Pick the earliest pending result; hand over when the output register frees
	assign out_free   = !out_valid_q || m_axis_tready;
	assign sel        = mask_q & (~mask_q + 3'd1);
	assign emit       = (mask_q != '0) && out_free;
	assign mask_left  = mask_q & ~sel;
	assign item_ready = (mask_q == '0) || (emit && (mask_left == '0));

	// Build the selected result word
	always_comb begin
		res_row = item_q.row;
		res_col = item_q.col;
		res_up  = '0;
		res_dn  = '0;
		res_lf  = '0;
		res_rt  = '0;
		case (sel)
			pnew_pkg::RES_ABOVE: begin
				res_row = item_q.row - 10'd1;
				res_up  = item_q.wa_up;
				res_dn  = item_q.wa_dn;
				res_lf  = item_q.wa_lf;
				res_rt  = item_q.wa_rt;
			end
			pnew_pkg::RES_LEFT: begin
				res_col = item_q.col - 10'd1;
				res_up  = item_q.wb_up;
				res_lf  = item_q.wb_lf;
				res_rt  = item_q.wb_rt;
			end
			pnew_pkg::RES_HERE: begin
				res_up  = item_q.wc_up;
				res_lf  = item_q.wc_lf;
			end
			default: res_row = item_q.row;
		endcase
	end

	// Control: pending mask and output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				mask_q <= item.mask;
			end else if (emit) begin
				mask_q <= mask_left;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: held item and output word
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
		if (emit) begin
			out_data_q <= {res_rt, res_lf, res_dn, res_up, res_col, res_row};
			out_last_q <= (mask_left == '0);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[26:20] <= pnew_pkg::WEIGHT_MAX)
			&& (m_axis_tdata[33:27] <= pnew_pkg::WEIGHT_MAX)
			&& (m_axis_tdata[40:34] <= pnew_pkg::WEIGHT_MAX)
			&& (m_axis_tdata[47:41] <= pnew_pkg::WEIGHT_MAX))
		else $error("edge weight above 100 on output");

	a_item_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid |-> item.mask != '0)
		else $error("item offered with no result to deliver");

endmodule
`default_nettype wire

>>> hdl/pixel_neighbor_edge_weights_core.sv
`default_nettype none
// Four-neighbor edge weights for a grid graph cut over a raster pixel stream.
// s_axis takes one pixel word per beat in raster order (tdata: blue, green, red
// from bit 0 up). m_axis gives result words: the pixel's row and column and its
// up, down, left and right weights, tlast on the final result caused by a pixel.
// cfg writes frame_width (index 0) and frame_height (index 1); write them between
// frames while the block is idle. A change takes effect on the next pixel.
// Results trail the input by one row: the pixel at (r, c) releases the result
// for (r-1, c), on the last row also (r, c-1) and, at its last column, (r, c).
// A result word reaches m_axis through the read stage, the sequencer's held item
// and its output register. While m_axis does not stall, throughput is one pixel
// per clock on every row but the last; there each pixel releases up to three words
// and the single-word output register drains one word per clock, so s_axis waits
// while they drain. The two line buffers are simple dual-port MAX_WIDTH x 24-bit
// memories with a registered read; the right neighbor is read one column ahead.
// Reset returns the counters to the frame origin and the registers to 160 x 120;
// the line buffers are not cleared. When m_axis stalls, the output word holds,
// the pending results stay queued, and s_axis tready drops once the queue is full.
module pixel_neighbor_edge_weights_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  pnew_pkg::cfg_index_t        cfg_index,
	input  pnew_pkg::cfg_data_t         cfg_data,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [23:0]                 s_axis_tdata,   // blue, green, red
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [47:0]                 m_axis_tdata,   // pixel_row, pixel_col, weight_up,
	                                                    // weight_down, weight_left, weight_right
	output logic                        m_axis_tlast    // last_of_run
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int XW = (CW + 1 > pnew_pkg::CFG_W) ? CW + 1 : pnew_pkg::CFG_W;
	localparam int YW = (RW + 1 > pnew_pkg::CFG_W) ? RW + 1 : pnew_pkg::CFG_W;

	pnew_pkg::cfg_data_t frame_width_q;
	pnew_pkg::cfg_data_t frame_height_q;
	logic [CW-1:0]       col_q;
	logic [RW-1:0]       row_q;
	pnew_pkg::pixel_t    first_px_q;
	pnew_pkg::pixel_t    prev_pixel_q;
	pnew_pkg::pixel_t    px1_q;
	pnew_pkg::pixel_t    px2_q;

	logic [XW-1:0]       w_eff;
	logic [YW-1:0]       h_eff;
	logic                last_col;
	logic                last_row;
	logic                r_ge1;
	logic                r_ge2;
	logic                c_ge1;
	logic                c_ge2;
	pnew_pkg::res_mask_t mask_in;
	pnew_pkg::pixel_t    px;
	pnew_pkg::pixel_t    above;
	logic [CW-1:0]       rd_addr;
	logic                in_fire;

	pnew_pkg::pixel_t    newer_rdata;
	pnew_pkg::pixel_t    older_rdata;

	logic                valid_s1;
	pnew_pkg::res_mask_t mask_s1;
	pnew_pkg::pixel_t    px_s1;
	pnew_pkg::pixel_t    above_s1;
	pnew_pkg::pixel_t    prev_pixel_s1;
	pnew_pkg::pixel_t    px1_s1;
	pnew_pkg::pixel_t    px2_s1;
	pnew_pkg::coord_t    row_s1;
	pnew_pkg::coord_t    col_s1;
	logic                r_ge1_s1;
	logic                r_ge2_s1;
	logic                c_ge1_s1;
	logic                c_ge2_s1;
	logic                last_col_s1;

	pnew_pkg::item_t     item;
	pnew_pkg::weight_t   w_above_px;
	pnew_pkg::weight_t   w_px1_px;
	logic                item_valid;
	logic                item_ready;
	logic                adv_s1;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= pnew_pkg::FRAME_WIDTH_RST;
			frame_height_q <= pnew_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				pnew_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				pnew_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default:                    frame_width_q  <= frame_width_q;
			endcase
		end
	end

	// Clamp the frame size: zero acts as one, above the maximum acts as the maximum
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = XW'(1);
		end else if (XW'(frame_width_q) > XW'(MAX_WIDTH)) begin
			w_eff = XW'(MAX_WIDTH);
		end else begin
			w_eff = XW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_eff = YW'(1);
		end else if (YW'(frame_height_q) > YW'(MAX_HEIGHT)) begin
			h_eff = YW'(MAX_HEIGHT);
		end else begin
			h_eff = YW'(frame_height_q);
		end
	end

	// Position flags and the set of results this pixel releases
	assign last_col = (XW'(col_q) + XW'(1)) >= w_eff;
	assign last_row = (YW'(row_q) + YW'(1)) >= h_eff;
	assign r_ge1    = YW'(row_q) >= YW'(1);
	assign r_ge2    = YW'(row_q) >= YW'(2);
	assign c_ge1    = XW'(col_q) >= XW'(1);
	assign c_ge2    = XW'(col_q) >= XW'(2);
	assign mask_in  = (r_ge1 ? pnew_pkg::RES_ABOVE : '0)
	                | ((last_row && c_ge1) ? pnew_pkg::RES_LEFT : '0)
	                | ((last_row && last_col) ? pnew_pkg::RES_HERE : '0);

	// Pixel above comes from the previous look-ahead read, or the column-0 copy
	assign px      = s_axis_tdata;
	assign above   = (col_q == '0) ? first_px_q : newer_rdata;
	assign rd_addr = (col_q == CW'(MAX_WIDTH - 1)) ? '0 : col_q + CW'(1);

	assign adv_s1        = valid_s1 && ((mask_s1 == '0) || item_ready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	pnew_line_buf #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_buf (
		.clk         (clk),
		.en          (in_fire),
		.wr_addr     (col_q),
		.rd_addr     (rd_addr),
		.newer_wdata (px),
		.older_wdata (above),
		.newer_rdata (newer_rdata),
		.older_rdata (older_rdata)
	);

	// Control: raster counters, stage valid, left-neighbor history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			valid_s1     <= 1'b0;
			mask_s1      <= '0;
			prev_pixel_q <= '0;
		end else begin
			if (in_fire) begin
				valid_s1     <= 1'b1;
				mask_s1      <= mask_in;
				prev_pixel_q <= above;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Payload: pixel history and read stage
	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (col_q == '0) begin
				first_px_q <= px;
			end
			px1_q         <= px;
			px2_q         <= px1_q;
			px_s1         <= px;
			above_s1      <= above;
			prev_pixel_s1 <= prev_pixel_q;
			px1_s1        <= px1_q;
			px2_s1        <= px2_q;
			row_s1        <= pnew_pkg::COORD_W'(row_q);
			col_s1        <= pnew_pkg::COORD_W'(col_q);
			r_ge1_s1      <= r_ge1;
			r_ge2_s1      <= r_ge2;
			c_ge1_s1      <= c_ge1;
			c_ge2_s1      <= c_ge2;
			last_col_s1   <= last_col;
		end
	end

	// Weights: line buffer data is valid while the pixel sits in the read stage
	assign w_above_px = pnew_pkg::edge_weight(above_s1, px_s1);
	assign w_px1_px   = pnew_pkg::edge_weight(px1_s1, px_s1);

	always_comb begin
		item.row   = row_s1;
		item.col   = col_s1;
		item.mask  = mask_s1;
		item.wa_up = r_ge2_s1 ? pnew_pkg::edge_weight(above_s1, older_rdata) : '0;
		item.wa_dn = w_above_px;
		item.wa_lf = c_ge1_s1 ? pnew_pkg::edge_weight(above_s1, prev_pixel_s1) : '0;
		item.wa_rt = !last_col_s1 ? pnew_pkg::edge_weight(above_s1, newer_rdata) : '0;
		item.wb_up = r_ge1_s1 ? pnew_pkg::edge_weight(px1_s1, prev_pixel_s1) : '0;
		item.wb_lf = c_ge2_s1 ? pnew_pkg::edge_weight(px1_s1, px2_s1) : '0;
		item.wb_rt = w_px1_px;
		item.wc_up = r_ge1_s1 ? w_above_px : '0;
		item.wc_lf = c_ge1_s1 ? w_px1_px : '0;
	end

	assign item_valid = valid_s1 && (mask_s1 != '0);

	pnew_result_seq u_result_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.item          (item),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= CW'(MAX_WIDTH - 1))
		else $error("column counter beyond line buffer depth");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= RW'(MAX_HEIGHT - 1))
		else $error("row counter beyond maximum height");

	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && last_col |=> col_q == '0)
		else $error("column counter did not wrap after last column");

endmodule
`default_nettype wire
